// File: hdl/cross_median_denoise_macros.svh
// ----------------------------------------------------------------------------
// Cross median denoise assertion macros
// Shared concurrent assertion forms, clocked on clk_i, off during reset.
// ----------------------------------------------------------------------------
`ifndef CROSS_MEDIAN_DENOISE_MACROS_SVH
`define CROSS_MEDIAN_DENOISE_MACROS_SVH

// same-cycle implication
`define CMD_ASSERT_NOW(lbl, ant, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CMD_ASSERT_NEXT(lbl, ant, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/cmd_pkg.sv
// ----------------------------------------------------------------------------
// Cross median denoise package
// Shared types and constants for the filter, its median unit and result queue.
// ----------------------------------------------------------------------------
`default_nettype none

package cmd_pkg;

  localparam int PIX_BITS    = 8;
  localparam int COL_BITS    = 10;
  localparam int ROW_BITS    = 16;
  localparam int WIDTH_BITS  = 11;
  localparam int HEIGHT_BITS = 16;

  localparam logic [WIDTH_BITS-1:0]  WIDTH_RESET  = 11'd640;
  localparam logic [HEIGHT_BITS-1:0] HEIGHT_RESET = 16'd480;

  localparam int APB_AW = 3;
  localparam int APB_DW = 32;

  localparam logic REG_IDX_WIDTH  = 1'b0;
  localparam logic REG_IDX_HEIGHT = 1'b1;

  localparam int MAX_RESULTS = 3;
  localparam int OQ_DEPTH    = 8;
  localparam int OQ_PW       = 3;
  localparam int OQ_CW       = 4;

  typedef struct packed {
    logic [PIX_BITS-1:0] pix;
    logic [COL_BITS-1:0] col;
    logic [ROW_BITS-1:0] row;
    logic                run_last;
    logic                frame_done;
  } res_t;

endpackage

`default_nettype wire

// File: hdl/cmd_ram.sv
// ----------------------------------------------------------------------------
// Cross median denoise RAM
// Generic RAM, one write port and two registered read ports.
// ----------------------------------------------------------------------------
`default_nettype none

module cmd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr0_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr1_i,
  output logic      [WIDTH-1:0]         rdata0_o,
  output logic      [WIDTH-1:0]         rdata1_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata0_o <= mem_q[raddr0_i];
    rdata1_o <= mem_q[raddr1_i];
  end

endmodule

`default_nettype wire

// File: hdl/cmd_med5.sv
// ----------------------------------------------------------------------------
// Cross median denoise median unit
// Median of five 8-bit values through a fixed min/max compare network.
// ----------------------------------------------------------------------------
`default_nettype none

module cmd_med5
  import cmd_pkg::*;
(
  input  wire logic [PIX_BITS-1:0] a_i,
  input  wire logic [PIX_BITS-1:0] b_i,
  input  wire logic [PIX_BITS-1:0] c_i,
  input  wire logic [PIX_BITS-1:0] d_i,
  input  wire logic [PIX_BITS-1:0] e_i,
  output logic      [PIX_BITS-1:0] med_o
);

  function automatic logic [PIX_BITS-1:0] min2(logic [PIX_BITS-1:0] x, logic [PIX_BITS-1:0] y);
    return (x < y) ? x : y;
  endfunction

  function automatic logic [PIX_BITS-1:0] max2(logic [PIX_BITS-1:0] x, logic [PIX_BITS-1:0] y);
    return (x > y) ? x : y;
  endfunction

  logic [PIX_BITS-1:0] lo_ab, hi_ab, lo_cd, hi_cd, f, g;

  always_comb begin
    lo_ab = min2(a_i, b_i);
    hi_ab = max2(a_i, b_i);
    lo_cd = min2(c_i, d_i);
    hi_cd = max2(c_i, d_i);
    f     = max2(lo_ab, lo_cd);
    g     = min2(hi_ab, hi_cd);
    // median of e, f, g
    med_o = max2(min2(e_i, f), min2(max2(e_i, f), g));
  end

endmodule

`default_nettype wire

// File: hdl/cmd_outq.sv
// ----------------------------------------------------------------------------
// Cross median denoise result queue
// Takes up to three results per cycle in order, gives one per cycle on ready.
// ----------------------------------------------------------------------------
`default_nettype none

module cmd_outq
  import cmd_pkg::*;
(
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic [MAX_RESULTS-1:0] push_vld_i,
  input  res_t                        push_res_i [MAX_RESULTS],
  output logic                        out_valid_o,
  input  wire logic                   out_ready_i,
  output res_t                        out_res_o,
  output logic      [OQ_CW-1:0]       count_o
);

  `include "cross_median_denoise_macros.svh"

  res_t             mem_q [OQ_DEPTH];
  logic [OQ_PW-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [OQ_CW-1:0] count_q, count_d;
  logic [OQ_CW-1:0] push_n;
  logic [OQ_PW-1:0] off_b, off_c;
  logic             pop;

  always_comb begin
    push_n  = OQ_CW'(push_vld_i[0]) + OQ_CW'(push_vld_i[1]) + OQ_CW'(push_vld_i[2]);
    off_b   = OQ_PW'(push_vld_i[0]);
    off_c   = OQ_PW'(push_vld_i[0]) + OQ_PW'(push_vld_i[1]);
    pop     = out_valid_o && out_ready_i;
    wptr_d  = wptr_q + OQ_PW'(push_n);
    rptr_d  = rptr_q + OQ_PW'(pop);
    count_d = count_q + push_n - OQ_CW'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (push_vld_i[0]) begin
      mem_q[wptr_q] <= push_res_i[0];
    end
    if (push_vld_i[1]) begin
      mem_q[wptr_q + off_b] <= push_res_i[1];
    end
    if (push_vld_i[2]) begin
      mem_q[wptr_q + off_c] <= push_res_i[2];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  assign out_valid_o = (count_q != '0);
  assign out_res_o   = mem_q[rptr_q];
  assign count_o     = count_q;

  `CMD_ASSERT_NOW(a_oq_bound, 1'b1, count_q <= OQ_CW'(OQ_DEPTH), "result queue overfilled")
  `CMD_ASSERT_NOW(a_oq_empty_ptrs, count_q == '0, rptr_q == wptr_q, "empty queue with apart pointers")

endmodule

`default_nettype wire

// File: hdl/cross_median_denoise.sv
// ----------------------------------------------------------------------------
// Cross median denoise
// Five-point cross median over a raster pixel stream, clamped at the borders.
// ----------------------------------------------------------------------------
// Channel   Dir  Handshake                 Payload
// pixel     in   in_valid_i / in_ready_o   pixel_in_i
// result    out  out_valid_o / out_ready_i pixel_out_o, out_col_o, out_row_o,
//                                          run_last_o, frame_done_o
// config    in   psel, penable, pwrite     paddr, pwdata, prdata, pready
//
// One item per cycle while the result queue has room: the accept cycle reads
// both line RAM copies, the next cycle forms up to three medians and writes the
// line entry back. Results are written into an 8-entry queue that feeds the
// output port. On the last row most items give two results, so the single
// result port holds back the input there.
// Reset clears counters, config, queue, s1 valid; not line RAMs or s1_q data.
// ----------------------------------------------------------------------------
`default_nettype none

module cross_median_denoise
  import cmd_pkg::*;
#(
  parameter int MAX_WIDTH = 1024
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [APB_AW-1:0]   paddr,
  input  wire logic [APB_DW-1:0]   pwdata,
  output logic      [APB_DW-1:0]   prdata,
  output logic                     pready,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire logic [PIX_BITS-1:0] pixel_in_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output logic      [PIX_BITS-1:0] pixel_out_o,
  output logic      [COL_BITS-1:0] out_col_o,
  output logic      [ROW_BITS-1:0] out_row_o,
  output logic                     run_last_o,
  output logic                     frame_done_o
);

  `include "cross_median_denoise_macros.svh"

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int CW = $clog2(MAX_WIDTH + 1);
  localparam int EW = (CW > WIDTH_BITS) ? CW : WIDTH_BITS;

  typedef struct packed {
    logic [PIX_BITS-1:0] o;
    logic [PIX_BITS-1:0] n;
  } line_t;

  typedef struct packed {
    logic [PIX_BITS-1:0] pix;
    logic [AW-1:0]       col;
    logic [ROW_BITS-1:0] row;
    logic                c_first;
    logic                c_last;
    logic                c_ge2;
    logic                r_first;
    logic                has_a;
    logic                has_b;
    logic                has_c;
    logic [1:0]          n;
  } s1_t;

  // configuration
  logic [WIDTH_BITS-1:0]  cfg_width_q;
  logic [HEIGHT_BITS-1:0] cfg_height_q;
  logic                   cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_width_q  <= WIDTH_RESET;
      cfg_height_q <= HEIGHT_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_IDX_WIDTH:  cfg_width_q  <= pwdata[WIDTH_BITS-1:0];
        REG_IDX_HEIGHT: cfg_height_q <= pwdata[HEIGHT_BITS-1:0];
        default:        cfg_width_q  <= cfg_width_q;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_IDX_WIDTH:  prdata = APB_DW'(cfg_width_q);
      REG_IDX_HEIGHT: prdata = APB_DW'(cfg_height_q);
      default:        prdata = '0;
    endcase
  end

  // position and stage 0
  logic [AW-1:0]       col_count_q;
  logic [ROW_BITS-1:0] row_count_q;
  logic [CW-1:0]       w_eff;
  logic [AW-1:0]       wm1;
  logic [ROW_BITS-1:0] hm1;
  s1_t                 s0;
  logic                in_accept;
  logic [AW-1:0]       ra [4];

  always_comb begin
    if (cfg_width_q == '0) begin
      w_eff = CW'(1);
    end else if (EW'(cfg_width_q) > EW'(MAX_WIDTH)) begin
      w_eff = CW'(MAX_WIDTH);
    end else begin
      w_eff = CW'(cfg_width_q);
    end
    wm1 = AW'(w_eff - CW'(1));
    hm1 = (cfg_height_q == '0) ? '0 : cfg_height_q - 16'd1;

    s0.pix     = pixel_in_i;
    s0.col     = (col_count_q < wm1) ? col_count_q : wm1;
    s0.row     = (row_count_q < hm1) ? row_count_q : hm1;
    s0.c_first = (s0.col == '0);
    s0.c_last  = (s0.col == wm1);
    s0.c_ge2   = (s0.col > AW'(1));
    s0.r_first = (s0.row == '0);
    s0.has_a   = !s0.r_first;
    s0.has_b   = (s0.row == hm1) && !s0.c_first;
    s0.has_c   = (s0.row == hm1) && s0.c_last;
    s0.n       = 2'(s0.has_a) + 2'(s0.has_b) + 2'(s0.has_c);

    ra[0] = s0.col;
    ra[1] = s0.col + AW'(1);
    ra[2] = s0.col - AW'(1);
    ra[3] = s0.col - AW'(2);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_count_q <= '0;
      row_count_q <= '0;
    end else if (in_accept) begin
      if (s0.c_last) begin
        col_count_q <= '0;
        row_count_q <= (s0.row == hm1) ? '0 : s0.row + 16'd1;
      end else begin
        col_count_q <= s0.col + AW'(1);
        row_count_q <= s0.row;
      end
    end
  end

  // line RAMs, two identical copies for four read addresses
  s1_t                 s1_q;
  logic                s1_valid_q;
  line_t               wdata;
  line_t               rd [4];
  line_t               fwd_data_q;
  logic [3:0]          fwd_q;
  line_t               e [4];

  cmd_ram #(
    .WIDTH ($bits(line_t)),
    .DEPTH (MAX_WIDTH)
  ) u_ram_near (
    .clk_i    (clk_i),
    .we_i     (s1_valid_q),
    .waddr_i  (s1_q.col),
    .wdata_i  (wdata),
    .raddr0_i (ra[0]),
    .raddr1_i (ra[1]),
    .rdata0_o (rd[0]),
    .rdata1_o (rd[1])
  );

  cmd_ram #(
    .WIDTH ($bits(line_t)),
    .DEPTH (MAX_WIDTH)
  ) u_ram_left (
    .clk_i    (clk_i),
    .we_i     (s1_valid_q),
    .waddr_i  (s1_q.col),
    .wdata_i  (wdata),
    .raddr0_i (ra[2]),
    .raddr1_i (ra[3]),
    .rdata0_o (rd[2]),
    .rdata1_o (rd[3])
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= in_accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_q <= s0;
    end
    fwd_data_q <= wdata;
    for (int i = 0; i < 4; i++) begin
      fwd_q[i] <= s1_valid_q && (ra[i] == s1_q.col);
    end
  end

  // stage 1: medians and write-back
  logic [PIX_BITS-1:0] ctr, lft, rgt, b_lft, c_lft, c_up;
  logic [PIX_BITS-1:0] med_a, med_b, med_c;
  logic [PIX_BITS-1:0] left_hold_q;
  res_t                res [MAX_RESULTS];
  logic [MAX_RESULTS-1:0] push_vld;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      e[i] = fwd_q[i] ? fwd_data_q : rd[i];
    end
    ctr   = e[0].n;
    lft   = s1_q.c_first ? ctr : left_hold_q;
    rgt   = s1_q.c_last ? ctr : e[1].n;
    b_lft = s1_q.c_ge2 ? e[3].n : e[2].n;
    c_lft = s1_q.c_first ? s1_q.pix : e[2].n;
    c_up  = s1_q.r_first ? s1_q.pix : ctr;
    wdata.n = s1_q.pix;
    wdata.o = s1_q.r_first ? s1_q.pix : ctr;
  end

  cmd_med5 u_med_a (
    .a_i   (ctr),
    .b_i   (lft),
    .c_i   (rgt),
    .d_i   (e[0].o),
    .e_i   (s1_q.pix),
    .med_o (med_a)
  );

  cmd_med5 u_med_b (
    .a_i   (e[2].n),
    .b_i   (b_lft),
    .c_i   (s1_q.pix),
    .d_i   (e[2].o),
    .e_i   (e[2].n),
    .med_o (med_b)
  );

  cmd_med5 u_med_c (
    .a_i   (s1_q.pix),
    .b_i   (c_lft),
    .c_i   (s1_q.pix),
    .d_i   (c_up),
    .e_i   (s1_q.pix),
    .med_o (med_c)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_hold_q <= '0;
    end else if (s1_valid_q) begin
      left_hold_q <= ctr;
    end
  end

  always_comb begin
    res[0].pix        = med_a;
    res[0].col        = COL_BITS'(s1_q.col);
    res[0].row        = s1_q.row - 16'd1;
    res[0].run_last   = !s1_q.has_b && !s1_q.has_c;
    res[0].frame_done = 1'b0;

    res[1].pix        = med_b;
    res[1].col        = COL_BITS'(s1_q.col - AW'(1));
    res[1].row        = s1_q.row;
    res[1].run_last   = !s1_q.has_c;
    res[1].frame_done = 1'b0;

    res[2].pix        = med_c;
    res[2].col        = COL_BITS'(s1_q.col);
    res[2].row        = s1_q.row;
    res[2].run_last   = 1'b1;
    res[2].frame_done = 1'b1;

    push_vld = {s1_q.has_c, s1_q.has_b, s1_q.has_a} & {MAX_RESULTS{s1_valid_q}};
  end

  // result queue
  logic [OQ_CW-1:0] oq_count;
  logic [1:0]       n1;
  res_t             head;

  cmd_outq u_outq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_vld_i  (push_vld),
    .push_res_i  (res),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_res_o   (head),
    .count_o     (oq_count)
  );

  assign n1 = s1_valid_q ? s1_q.n : 2'd0;
  assign in_ready_o = ((OQ_CW + 1)'(oq_count) + (OQ_CW + 1)'(n1) + (OQ_CW + 1)'(MAX_RESULTS))
                      <= (OQ_CW + 1)'(OQ_DEPTH);
  assign in_accept  = in_valid_i && in_ready_o;

  assign pixel_out_o  = head.pix;
  assign out_col_o    = head.col;
  assign out_row_o    = head.row;
  assign run_last_o   = head.run_last;
  assign frame_done_o = head.frame_done;

  `CMD_ASSERT_NEXT(a_s1_follows, in_accept, s1_valid_q, "accepted item missing from compute stage")
  `CMD_ASSERT_NOW(a_done_last, out_valid_o && frame_done_o, run_last_o, "frame end not last of its item")
  `CMD_ASSERT_NOW(a_frame_wrap, s1_valid_q && s1_q.has_c, col_count_q == '0 && row_count_q == '0, "counters not wrapped at frame end")

endmodule

`default_nettype wire

// File: tb/tb_top.sv
// ----------------------------------------------------------------------------
// Cross median denoise testbench
// Streams raster frames through the filter over a valid/ready channel, changes
// the frame size through the APB port between frames and in mid-frame, and
// checks every result against a cycle-free predictor of the cross median, or
// for marked items against the table's value. Starts with a table of directed
// items, then random frames with random sender bursts and receiver stalls.
// ----------------------------------------------------------------------------
module tb_top;
  import cmd_pkg::*;

  localparam int LINE_MAX    = 1024;
  localparam int CYCLE_LIMIT = 500000;
  localparam int DRAIN_WAIT  = 8;

  typedef enum logic [1:0] {OP_PIX, OP_WIDTH, OP_HEIGHT} plan_op_e;

  typedef struct packed {
    plan_op_e     op;
    logic [15:0]  val;
    logic         chk;
    res_t         want;
  } plan_t;

  localparam res_t NO_RES = '0;
  localparam int   PLAN_LEN = 37;
  localparam plan_t PLAN [0:PLAN_LEN-1] = '{
    '{OP_PIX,    16'h003c, 1'b0, NO_RES},
    '{OP_WIDTH,  16'd0,    1'b0, NO_RES},
    '{OP_HEIGHT, 16'd0,    1'b0, NO_RES},
    '{OP_PIX,    16'h0000, 1'b1, '{8'h00, 10'd0, 16'd0, 1'b1, 1'b1}},
    '{OP_PIX,    16'h00ff, 1'b1, '{8'hff, 10'd0, 16'd0, 1'b1, 1'b1}},
    '{OP_PIX,    16'h005a, 1'b1, '{8'h5a, 10'd0, 16'd0, 1'b1, 1'b1}},
    '{OP_WIDTH,  16'd2,    1'b0, NO_RES},
    '{OP_HEIGHT, 16'd1,    1'b0, NO_RES},
    '{OP_PIX,    16'h0010, 1'b0, NO_RES},
    '{OP_PIX,    16'h00f0, 1'b0, NO_RES},
    '{OP_WIDTH,  16'd3,    1'b0, NO_RES},
    '{OP_HEIGHT, 16'd3,    1'b0, NO_RES},
    '{OP_PIX,    16'h0000, 1'b0, NO_RES},
    '{OP_PIX,    16'h00ff, 1'b0, NO_RES},
    '{OP_PIX,    16'h0011, 1'b0, NO_RES},
    '{OP_PIX,    16'h00c8, 1'b0, NO_RES},
    '{OP_PIX,    16'h0003, 1'b0, NO_RES},
    '{OP_PIX,    16'h00ff, 1'b0, NO_RES},
    '{OP_PIX,    16'h0000, 1'b0, NO_RES},
    '{OP_PIX,    16'h0080, 1'b0, NO_RES},
    '{OP_PIX,    16'h0009, 1'b0, NO_RES},
    '{OP_WIDTH,  16'd5,    1'b0, NO_RES},
    '{OP_HEIGHT, 16'd2,    1'b0, NO_RES},
    '{OP_PIX,    16'h0040, 1'b0, NO_RES},
    '{OP_PIX,    16'h0041, 1'b0, NO_RES},
    '{OP_PIX,    16'h0042, 1'b0, NO_RES},
    '{OP_WIDTH,  16'd2,    1'b0, NO_RES},
    '{OP_PIX,    16'h0090, 1'b0, NO_RES},
    '{OP_PIX,    16'h0007, 1'b0, NO_RES},
    '{OP_PIX,    16'h00e0, 1'b0, NO_RES},
    '{OP_WIDTH,  16'd1,    1'b0, NO_RES},
    '{OP_HEIGHT, 16'hffff, 1'b0, NO_RES},
    '{OP_PIX,    16'h0001, 1'b0, NO_RES},
    '{OP_PIX,    16'h00fe, 1'b0, NO_RES},
    '{OP_PIX,    16'h007f, 1'b0, NO_RES},
    '{OP_HEIGHT, 16'd2,    1'b0, NO_RES},
    '{OP_PIX,    16'h0080, 1'b0, NO_RES}
  };

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [APB_AW-1:0] paddr = '0;
  logic [APB_DW-1:0] pwdata = '0;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [PIX_BITS-1:0] pixel_in = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [PIX_BITS-1:0] pixel_out;
  logic [COL_BITS-1:0] out_col;
  logic [ROW_BITS-1:0] out_row;
  logic                run_last;
  logic                frame_done;

  logic [WIDTH_BITS-1:0]  cfg_width = WIDTH_RESET;
  logic [HEIGHT_BITS-1:0] cfg_height = HEIGHT_RESET;
  logic [7:0] prev_row [LINE_MAX];
  logic [7:0] prev2_row [LINE_MAX];
  bit         col_filled [LINE_MAX];
  int         nx_col = 0;
  int         nx_row = 0;
  logic [7:0] left_keep = '0;

  res_t median_q[$];
  res_t step_out[$];
  res_t mon_want;
  res_t mon_got;
  int   bad_cnt = 0;
  int   cyc = 0;
  int   burst_left = 0;
  int   sent = 0;
  logic [7:0] last_px = '0;

  int rx_mode = 0;
  int rx_left = 0;
  int rx_run = 0;

  always #5 clk_i = ~clk_i;

  cross_median_denoise u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .pixel_in_i   (pixel_in),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .pixel_out_o  (pixel_out),
    .out_col_o    (out_col),
    .out_row_o    (out_row),
    .run_last_o   (run_last),
    .frame_done_o (frame_done)
  );

  function automatic int eff_width(input logic [WIDTH_BITS-1:0] v);
    int w;
    w = v;
    if (w == 0) w = 1;
    if (w > LINE_MAX) w = LINE_MAX;
    return w;
  endfunction

  function automatic int eff_height(input logic [HEIGHT_BITS-1:0] v);
    int h;
    h = v;
    if (h == 0) h = 1;
    return h;
  endfunction

  function automatic logic [7:0] mid5(input logic [7:0] a, input logic [7:0] b,
                                      input logic [7:0] c, input logic [7:0] d,
                                      input logic [7:0] e);
    logic [7:0] v [5];
    logic [7:0] m;
    int lt;
    int le;
    v[0] = a; v[1] = b; v[2] = c; v[3] = d; v[4] = e;
    m = '0;
    for (int i = 0; i < 5; i++) begin
      lt = 0;
      le = 0;
      for (int j = 0; j < 5; j++) begin
        if (v[j] < v[i]) lt++;
        if (v[j] <= v[i]) le++;
      end
      if (lt <= 2 && le >= 3) m = v[i];
    end
    return m;
  endfunction

  function automatic res_t make_res(input logic [7:0] pix, input int c, input int r);
    res_t o;
    o = '0;
    o.pix = pix;
    o.col = c[COL_BITS-1:0];
    o.row = r[ROW_BITS-1:0];
    return o;
  endfunction

  function automatic int filled_span();
    int n;
    n = 0;
    while (n < LINE_MAX && col_filled[n]) n++;
    return n;
  endfunction

  function automatic logic [7:0] pick_pixel();
    logic [7:0] p;
    case ($urandom_range(0, 9))
      0: p = 8'h00;
      1: p = 8'hff;
      2: p = last_px;
      default: p = $urandom_range(0, 255);
    endcase
    last_px = p;
    return p;
  endfunction

  task automatic filter_pixel(input logic [7:0] px);
    int w, h, c, r, n;
    res_t outs [3];
    logic [7:0] ctr, lft, rgt, up;
    w = eff_width(cfg_width);
    h = eff_height(cfg_height);
    c = (nx_col < w - 1) ? nx_col : w - 1;
    r = (nx_row < h - 1) ? nx_row : h - 1;
    n = 0;
    if (r >= 1) begin
      ctr = prev_row[c];
      lft = (c == 0) ? ctr : left_keep;
      rgt = (c == w - 1) ? ctr : prev_row[c + 1];
      outs[n] = make_res(mid5(ctr, lft, rgt, prev2_row[c], px), c, r - 1);
      n++;
    end
    if (r == h - 1) begin
      if (c >= 1) begin
        ctr = prev_row[c - 1];
        lft = (c >= 2) ? prev_row[c - 2] : ctr;
        outs[n] = make_res(mid5(ctr, lft, px, prev2_row[c - 1], ctr), c - 1, r);
        n++;
      end
      if (c == w - 1) begin
        lft = (c >= 1) ? prev_row[c - 1] : px;
        up = (r == 0) ? px : prev_row[c];
        outs[n] = make_res(mid5(px, lft, px, up, px), c, r);
        outs[n].frame_done = 1'b1;
        n++;
      end
    end
    if (n > 0) outs[n - 1].run_last = 1'b1;
    for (int i = 0; i < n; i++) step_out.push_back(outs[i]);

    left_keep = prev_row[c];
    prev2_row[c] = (r == 0) ? px : prev_row[c];
    prev_row[c] = px;
    col_filled[c] = 1'b1;
    if (c == w - 1) begin
      nx_col = 0;
      nx_row = (r == h - 1) ? 0 : r + 1;
    end else begin
      nx_col = c + 1;
      nx_row = r;
    end
  endtask

  task automatic send_pixel(input logic [7:0] px, input bit chk, input res_t want);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 30);
    end
    burst_left--;
    in_valid <= 1'b1;
    pixel_in <= px;
    do @(posedge clk_i); while (!in_ready);
    sent++;
    step_out.delete();
    filter_pixel(px);
    if (chk) median_q.push_back(want);
    else foreach (step_out[i]) median_q.push_back(step_out[i]);
  endtask

  task automatic send_random();
    send_pixel(pick_pixel(), 1'b0, NO_RES);
  endtask

  // hold off until every item has drained out of the filter
  task automatic settle();
    in_valid <= 1'b0;
    while (median_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    burst_left = 0;
  endtask

  task automatic write_reg(input logic idx, input logic [APB_DW-1:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == REG_IDX_WIDTH) cfg_width = val[WIDTH_BITS-1:0];
    else cfg_height = val[HEIGHT_BITS-1:0];
    @(posedge clk_i);
  endtask

  task automatic finish_frame();
    while (nx_col != 0 || nx_row != 0) send_random();
  endtask

  always @(posedge clk_i) begin
    if (rx_left == 0) begin
      rx_mode <= $urandom_range(0, 2);
      rx_left <= $urandom_range(20, 200);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= $urandom_range(0, 1);
      default: begin
        if (rx_run == 0) begin
          out_ready <= !out_ready;
          rx_run <= out_ready ? $urandom_range(1, 12) : $urandom_range(1, 4);
        end else begin
          rx_run <= rx_run - 1;
        end
      end
    endcase
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid && out_ready) begin
      mon_got = '{pixel_out, out_col, out_row, run_last, frame_done};
      if (median_q.size() == 0) begin
        bad_cnt++;
        if (bad_cnt <= 10)
          $display("unexpected item: pix=%0d col=%0d row=%0d last=%0b done=%0b",
                   mon_got.pix, mon_got.col, mon_got.row, mon_got.run_last,
                   mon_got.frame_done);
      end else begin
        mon_want = median_q.pop_front();
        if (mon_got.pix !== mon_want.pix || mon_got.col !== mon_want.col ||
            mon_got.row !== mon_want.row || mon_got.run_last !== mon_want.run_last ||
            mon_got.frame_done !== mon_want.frame_done) begin
          bad_cnt++;
          if (bad_cnt <= 10)
            $display("mismatch: expected pix=%0d col=%0d row=%0d last=%0b done=%0b, got pix=%0d col=%0d row=%0d last=%0b done=%0b",
                     mon_want.pix, mon_want.col, mon_want.row, mon_want.run_last,
                     mon_want.frame_done, mon_got.pix, mon_got.col, mon_got.row,
                     mon_got.run_last, mon_got.frame_done);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cyc <= cyc + 1;
    if (cyc == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    int base;
    int w;
    int k;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < PLAN_LEN; i++) begin
      case (PLAN[i].op)
        OP_PIX: send_pixel(PLAN[i].val[7:0], PLAN[i].chk, PLAN[i].want);
        OP_WIDTH: begin
          settle();
          write_reg(REG_IDX_WIDTH, {16'h0, PLAN[i].val});
        end
        default: begin
          settle();
          write_reg(REG_IDX_HEIGHT, {16'h0, PLAN[i].val});
        end
      endcase
    end

    // widest line, clamped to the store depth
    settle();
    write_reg(REG_IDX_WIDTH, 32'h7ff);
    write_reg(REG_IDX_HEIGHT, 32'd2);
    finish_frame();

    // tallest frame, cut short in mid-frame
    settle();
    w = $urandom_range(2, 6);
    write_reg(REG_IDX_WIDTH, w);
    write_reg(REG_IDX_HEIGHT, 32'hffff);
    repeat (2 * w + $urandom_range(1, w)) send_random();
    settle();
    write_reg(REG_IDX_HEIGHT, $urandom_range(1, 2));
    finish_frame();

    base = sent;
    while (sent - base < 100) begin
      settle();
      write_reg(REG_IDX_WIDTH, $urandom_range(0, 9));
      write_reg(REG_IDX_HEIGHT, $urandom_range(0, 5));
      k = eff_width(cfg_width) * eff_height(cfg_height);
      if (k > 1 && $urandom_range(0, 2) == 0) begin
        repeat ($urandom_range(1, k - 1)) send_random();
        settle();
        if ($urandom_range(0, 1) == 0) begin
          w = filled_span();
          write_reg(REG_IDX_WIDTH, $urandom_range(0, (w < 10) ? w : 10));
        end else begin
          write_reg(REG_IDX_HEIGHT, $urandom_range(0, 5));
        end
      end
      finish_frame();
    end

    in_valid <= 1'b0;
    while (median_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (bad_cnt == 0 && median_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+hdl
hdl/cmd_pkg.sv
hdl/cmd_ram.sv
hdl/cmd_med5.sv
hdl/cmd_outq.sv
hdl/cross_median_denoise.sv
tb/tb_top.sv
